// ----- sv/scalar_kalman_angle_filter_top_macros.svh -----
// Assertion macros shared by the angle filter RTL.
`ifndef SCALAR_KALMAN_ANGLE_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SKAF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define SKAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKAF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SKAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/skaf_pkg.sv -----
// Shared types, constants and saturation helpers for the angle filter.
package skaf_pkg;

  localparam int ANGLE_W   = 32;
  localparam int COV_W     = 31;
  localparam int DT_W      = 16;
  localparam int GAIN_W    = 17;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 34;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_W    = 16;
  localparam int SHIFTED_W = PROD_W - FRAC_W;
  localparam int WIDE_W    = 68;
  localparam int CFG_IDX_W = 3;

  localparam logic [COV_W-1:0]  PROCESS_NOISE_RST      = 31'd655;
  localparam logic [COV_W-1:0]  MEASUREMENT_NOISE_RST  = 31'd6554;
  localparam logic [COV_W-1:0]  INITIAL_COVARIANCE_RST = 31'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ONE               = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS          = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED_MUL,
    ST_PRED_ADD,
    ST_DTQ,
    ST_PB,
    ST_INNER,
    ST_INF_MUL,
    ST_INF_ADD,
    ST_DIV_START,
    ST_DIV,
    ST_COR_MUL,
    ST_COR_ADD,
    ST_SHRINK,
    ST_EMIT
  } state_t;

  // Configuration values and the covariance reload seen by the core.
  typedef struct packed {
    logic [COV_W-1:0]          process_noise;
    logic [COV_W-1:0]          measurement_noise;
    logic signed [ANGLE_W-1:0] gyro_bias;
    logic                      load_cov;
    logic [COV_W-1:0]          load_value;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [COV_W-1:0] numer;
    logic [31:0]      denom;
  } div_ctl_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] quot;
  } div_stat_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [ANGLE_W-1:0] res;
    if (x > 68'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[ANGLE_W-1:0];
    end
    return res;
  endfunction

  // Clamp a wide signed value to the covariance range [0, 2^31-1].
  function automatic logic [COV_W-1:0] clamp_cov(input logic signed [WIDE_W-1:0] x);
    logic [COV_W-1:0] res;
    if (x < 68'sd0) begin
      res = '0;
    end else if (x > 68'sd2147483647) begin
      res = 31'h7FFF_FFFF;
    end else begin
      res = x[COV_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- sv/skaf_in_if.sv -----
// Input channel carrying one sensor item.
interface skaf_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         gyro_rate;
  logic [15:0]                time_step;
  logic signed [31:0]         measured_angle;

  modport source (output valid, output gyro_rate, output time_step, output measured_angle,
                  input ready);
  modport sink (input valid, input gyro_rate, input time_step, input measured_angle,
                output ready);
endinterface

// ----- sv/skaf_out_if.sv -----
// Output channel carrying one angle estimate.
interface skaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimated_angle;

  modport source (output valid, output estimated_angle, input ready);
  modport sink (input valid, input estimated_angle, output ready);
endinterface

// ----- sv/skaf_cfg_if.sv -----
// Configuration write channel.
interface skaf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/skaf_mul.sv -----
// Shared signed multiplier with a registered product.
module skaf_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [skaf_pkg::MUL_A_W-1:0]  a,
  input  logic signed [skaf_pkg::MUL_B_W-1:0]  b,
  output logic signed [skaf_pkg::PROD_W-1:0]   prod
);

  // One product per cycle while en is high, held until the next enabled cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ----- sv/skaf_div.sv -----
// Restoring divider producing the 17-bit gain floor(numer * 2^16 / denom).
module skaf_div (
  input  logic                clk,
  input  logic                rst,
  input  skaf_pkg::div_ctl_t  ctl,
  output skaf_pkg::div_stat_t stat
);

  logic [32:0]                    rem;
  logic [31:0]                    den;
  logic [4:0]                     cnt;
  logic                           busy;
  logic [skaf_pkg::GAIN_W-1:0]    quot;
  logic                           ge;
  logic [32:0]                    rem_sub;
  logic [32:0]                    rem_keep;

  // One quotient bit per cycle: compare, conditionally subtract, shift.
  always_comb begin
    ge       = rem >= {1'b0, den};
    rem_sub  = rem - {1'b0, den};
    rem_keep = ge ? rem_sub : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= 5'(skaf_pkg::GAIN_W);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // Quotient and remainder datapath; the numerator is below twice the divisor.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= {2'b00, ctl.numer};
      den  <= ctl.denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= {rem_keep[31:0], 1'b0};
      quot <= {quot[skaf_pkg::GAIN_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.quot = quot;

endmodule

// ----- sv/skaf_core.sv -----
// Filter sequencer and datapath around the shared multiplier and divider.
`include "scalar_kalman_angle_filter_top_macros.svh"

module skaf_core (
  input  logic                                clk,
  input  logic                                rst,
  input  skaf_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  in_gyro_rate,
  input  logic [15:0]                         in_time_step,
  input  logic signed [31:0]                  in_measured_angle,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [31:0]                  res_angle
);

  skaf_pkg::state_t state;
  skaf_pkg::state_t state_next;

  logic signed [skaf_pkg::ANGLE_W-1:0]   angle;
  logic [skaf_pkg::COV_W-1:0]            cov;
  logic [skaf_pkg::DT_W-1:0]             dt;
  logic signed [skaf_pkg::ANGLE_W-1:0]   meas;
  logic signed [skaf_pkg::ANGLE_W:0]     diff;
  logic [skaf_pkg::COV_W-1:0]            dtq;
  logic signed [skaf_pkg::ANGLE_W-1:0]   pb2;
  logic signed [skaf_pkg::ANGLE_W-1:0]   inner;
  logic [skaf_pkg::GAIN_W-1:0]           k;
  logic signed [skaf_pkg::ANGLE_W:0]     err;

  logic                                  mul_en;
  logic signed [skaf_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [skaf_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [skaf_pkg::PROD_W-1:0]    prod;
  logic signed [skaf_pkg::SHIFTED_W-1:0] prod_sh;
  logic signed [skaf_pkg::WIDE_W-1:0]    prod_wide;
  logic signed [skaf_pkg::ANGLE_W-1:0]   pb1;
  logic [31:0]                           den;
  logic [skaf_pkg::GAIN_W-1:0]           one_minus_k;

  skaf_pkg::div_ctl_t  div_ctl;
  skaf_pkg::div_stat_t div_st;

  skaf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  skaf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .stat (div_st)
  );

  // Product shifted down by 16 bits rounds toward minus infinity.
  always_comb begin
    prod_sh     = prod[skaf_pkg::PROD_W-1:skaf_pkg::FRAC_W];
    prod_wide   = {{(skaf_pkg::WIDE_W - skaf_pkg::SHIFTED_W){prod_sh[skaf_pkg::SHIFTED_W-1]}},
                   prod_sh};
    pb1         = skaf_pkg::sat32(prod_wide);
    den         = {1'b0, cov} + {1'b0, cfg.measurement_noise};
    one_minus_k = skaf_pkg::GAIN_ONE - k;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      skaf_pkg::ST_IDLE:      if (in_valid) state_next = skaf_pkg::ST_PRED_MUL;
      skaf_pkg::ST_PRED_MUL:  state_next = skaf_pkg::ST_PRED_ADD;
      skaf_pkg::ST_PRED_ADD:  state_next = skaf_pkg::ST_DTQ;
      skaf_pkg::ST_DTQ:       state_next = skaf_pkg::ST_PB;
      skaf_pkg::ST_PB:        state_next = skaf_pkg::ST_INNER;
      skaf_pkg::ST_INNER:     state_next = skaf_pkg::ST_INF_MUL;
      skaf_pkg::ST_INF_MUL:   state_next = skaf_pkg::ST_INF_ADD;
      skaf_pkg::ST_INF_ADD:   state_next = skaf_pkg::ST_DIV_START;
      skaf_pkg::ST_DIV_START: begin
        state_next = (den == 32'd0) ? skaf_pkg::ST_COR_MUL : skaf_pkg::ST_DIV;
      end
      skaf_pkg::ST_DIV:       if (!div_st.busy) state_next = skaf_pkg::ST_COR_MUL;
      skaf_pkg::ST_COR_MUL:   state_next = skaf_pkg::ST_COR_ADD;
      skaf_pkg::ST_COR_ADD:   state_next = skaf_pkg::ST_SHRINK;
      skaf_pkg::ST_SHRINK:    state_next = skaf_pkg::ST_EMIT;
      skaf_pkg::ST_EMIT:      if (res_ready) state_next = skaf_pkg::ST_IDLE;
      default:                state_next = skaf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes, divider start and multiplier operands.
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_ctl.start = 1'b0;
    div_ctl.numer = cov;
    div_ctl.denom = den;
    case (state)
      skaf_pkg::ST_IDLE: in_ready = 1'b1;
      skaf_pkg::ST_PRED_MUL: begin
        mul_en = 1'b1;
        mul_a  = {17'd0, dt};
        mul_b  = {diff[skaf_pkg::ANGLE_W], diff};
      end
      skaf_pkg::ST_PRED_ADD: begin
        mul_en = 1'b1;
        mul_a  = {17'd0, dt};
        mul_b  = {3'd0, cfg.process_noise};
      end
      skaf_pkg::ST_DTQ: begin
        mul_en = 1'b1;
        mul_a  = {2'd0, cov};
        mul_b  = {{2{cfg.gyro_bias[31]}}, cfg.gyro_bias};
      end
      skaf_pkg::ST_INF_MUL: begin
        mul_en = 1'b1;
        mul_a  = {17'd0, dt};
        mul_b  = {{2{inner[31]}}, inner};
      end
      skaf_pkg::ST_DIV_START: div_ctl.start = (den != 32'd0);
      skaf_pkg::ST_COR_MUL: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, k};
        mul_b  = {err[skaf_pkg::ANGLE_W], err};
      end
      skaf_pkg::ST_COR_ADD: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, one_minus_k};
        mul_b  = {3'd0, cov};
      end
      skaf_pkg::ST_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Filter state: angle estimate and error covariance.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      cov   <= skaf_pkg::INITIAL_COVARIANCE_RST;
    end else if (cfg.load_cov) begin
      cov <= cfg.load_value;
    end else begin
      case (state)
        skaf_pkg::ST_PRED_ADD, skaf_pkg::ST_COR_ADD: begin
          angle <= skaf_pkg::sat32({{36{angle[31]}}, angle} + prod_wide);
        end
        skaf_pkg::ST_INF_ADD: cov <= skaf_pkg::clamp_cov({37'd0, cov} + prod_wide);
        skaf_pkg::ST_SHRINK:  cov <= skaf_pkg::clamp_cov(prod_wide);
        default: ;
      endcase
    end
  end

  // Working registers for one item.
  always_ff @(posedge clk) begin
    case (state)
      skaf_pkg::ST_IDLE: begin
        dt   <= in_time_step;
        meas <= in_measured_angle;
        diff <= {in_gyro_rate[31], in_gyro_rate} - {cfg.gyro_bias[31], cfg.gyro_bias};
      end
      skaf_pkg::ST_DTQ:   dtq <= prod_sh[skaf_pkg::COV_W-1:0];
      skaf_pkg::ST_PB:    pb2 <= skaf_pkg::sat32({{35{pb1[31]}}, pb1, 1'b0});
      skaf_pkg::ST_INNER: begin
        inner <= skaf_pkg::sat32({37'd0, dtq} - {{36{pb2[31]}}, pb2}
                                 + {37'd0, cfg.measurement_noise});
      end
      skaf_pkg::ST_INF_ADD:   err <= {meas[31], meas} - {angle[31], angle};
      skaf_pkg::ST_DIV_START: k <= '0;
      skaf_pkg::ST_DIV:       if (!div_st.busy) k <= div_st.quot;
      default: ;
    endcase
  end

  assign res_angle = angle;

  `SKAF_ASSERT_NEXT(a_div_busy_after_start, clk, rst, div_ctl.start, div_st.busy)
  `SKAF_ASSERT_IMP(a_div_quiet_when_idle, clk, rst, state == skaf_pkg::ST_IDLE, !div_st.busy)
  `SKAF_ASSERT_IMP(a_gain_in_range, clk, rst, state == skaf_pkg::ST_COR_MUL, k <= skaf_pkg::GAIN_ONE)

endmodule

// ----- sv/scalar_kalman_angle_filter_top.sv -----
// Scalar Kalman angle filter: configuration registers, output register and core.
// Items are processed one at a time: the core takes a new item only when idle. Each item
// runs the sequence of shared-multiplier steps and, unless the denominator is zero, the
// 17-step gain divider; the next item is taken while a result waits in the output register.
// Reset (synchronous, rst high) restores register defaults, clears the angle and loads
// the covariance with the default initial covariance.
module scalar_kalman_angle_filter_top (
  input  logic       clk,
  input  logic       rst,
  skaf_in_if.sink    in_ch,
  skaf_out_if.source out_ch,
  skaf_cfg_if.sink   cfg
);

  logic [skaf_pkg::COV_W-1:0]          process_noise;
  logic [skaf_pkg::COV_W-1:0]          measurement_noise;
  logic signed [skaf_pkg::ANGLE_W-1:0] gyro_bias;
  skaf_pkg::cfg_t                      core_cfg;

  logic                                res_valid;
  logic                                res_ready;
  logic signed [31:0]                  res_angle;
  logic                                out_valid;
  logic signed [31:0]                  out_angle;
  logic                                cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= skaf_pkg::PROCESS_NOISE_RST;
      measurement_noise <= skaf_pkg::MEASUREMENT_NOISE_RST;
      gyro_bias         <= '0;
    end else if (cfg_wr) begin
      case (cfg.index)
        skaf_pkg::CFG_PROCESS_NOISE:     process_noise     <= cfg.data[skaf_pkg::COV_W-1:0];
        skaf_pkg::CFG_MEASUREMENT_NOISE: measurement_noise <= cfg.data[skaf_pkg::COV_W-1:0];
        skaf_pkg::CFG_GYRO_BIAS:         gyro_bias         <= cfg.data;
        default: ;
      endcase
    end
  end

  // Writing the initial covariance reloads the covariance state in the core.
  always_comb begin
    core_cfg.process_noise     = process_noise;
    core_cfg.measurement_noise = measurement_noise;
    core_cfg.gyro_bias         = gyro_bias;
    core_cfg.load_cov          = cfg_wr && (cfg.index == skaf_pkg::CFG_INITIAL_COVARIANCE);
    core_cfg.load_value        = cfg.data[skaf_pkg::COV_W-1:0];
  end

  skaf_core u_core (
    .clk               (clk),
    .rst               (rst),
    .cfg               (core_cfg),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_gyro_rate      (in_ch.gyro_rate),
    .in_time_step      (in_ch.time_step),
    .in_measured_angle (in_ch.measured_angle),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res_angle         (res_angle)
  );

  // Output register holds one estimate until the sink takes it.
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_angle <= res_angle;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.estimated_angle = out_angle;

endmodule
